// ===== src/hat_pkg.sv =====
// shared constants and types for the hash aggregate table
package hat_pkg;

  localparam int TABLE_SLOTS = 128;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 32;
  localparam int SUM_W       = 32;
  localparam int SLOT_W      = 7;
  localparam int ENTRY_W     = KEY_W + SUM_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic signed [SUM_W-1:0] MISS_SUM = '1;

  typedef enum logic [2:0] {
    ST_NEW    = 3'd0,
    ST_ADDED  = 3'd1,
    ST_FULL   = 3'd2,
    ST_HIT    = 3'd3,
    ST_MISS   = 3'd4
  } status_t;

  typedef enum logic {
    PH_IDLE,
    PH_PROBE
  } phase_t;

endpackage

// ===== src/hat_in_if.sv =====
// input word channel: kind, key and value
interface hat_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [hat_pkg::KEY_W-1:0] key;
  logic signed [hat_pkg::SUM_W-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink (input valid, input kind, input key, input value, output ready);
endinterface

// ===== src/hat_out_if.sv =====
// result word channel: status, sum and slot
interface hat_out_if;
  logic                              valid;
  logic                              ready;
  hat_pkg::status_t                  status;
  logic signed [hat_pkg::SUM_W-1:0]  sum;
  logic        [hat_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output status, output sum, output slot, input ready);
  modport sink (input valid, input status, input sum, input slot, output ready);
endinterface

// ===== src/hat_ram.sv =====
// generic single-write, single-read ram with registered read data
module hat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hash_aggregate_table.sv =====
// group-by-sum hash table with quadratic probing, top level
//
// Each input word either adds its value to the running 32-bit sum of its key
// (claiming a free slot for a new key; full if none is found) or looks up
// that sum, and produces one result word. The home slot is the key's low
// bits; probe i visits home + i*i modulo the slot count, which must be a
// power of two. Keys and sums live in one ram with a registered read;
// occupancy flags are flip-flops cleared by reset, so the block is usable
// right after reset with no clearing pass. One probe is done per cycle,
// pipelined against the ram read port. A word is accepted in the idle phase
// and then probed, at most 16 probes at 128 slots; no new word is taken
// until its result is written to the output register. A finishing probe
// waits for as long as the output register still holds a result that has
// not been taken. A finished result waits in the output register while the
// next word is accepted.
module hash_aggregate_table (
  input  logic              clk,
  input  logic              rst_n,
  hat_in_if.sink            in_ch,
  hat_out_if.source         out_ch
);

  hat_pkg::phase_t                   phase_r, phase_nxt;
  logic                              kind_r, kind_nxt;
  logic [hat_pkg::KEY_W-1:0]         key_r, key_nxt;
  logic [hat_pkg::SUM_W-1:0]         val_r, val_nxt;
  logic [hat_pkg::IDX_W-1:0]         home_r, home_nxt;
  logic [hat_pkg::IDX_W-1:0]         cur_idx_r, cur_idx_nxt;
  logic [hat_pkg::IDX_W-1:0]         sq_r, sq_nxt;
  logic [hat_pkg::IDX_W-1:0]         delta_r, delta_nxt;
  logic [hat_pkg::TABLE_SLOTS-1:0]   occupied_r;

  logic                              out_valid_r;
  hat_pkg::status_t                  out_status_r;
  logic [hat_pkg::SUM_W-1:0]         out_sum_r;
  logic [hat_pkg::SLOT_W-1:0]        out_slot_r;

  logic [hat_pkg::IDX_W-1:0]         in_home;
  logic [hat_pkg::IDX_W-1:0]         ram_raddr;
  logic                              ram_we;
  logic [hat_pkg::SUM_W-1:0]         wr_sum;
  logic [hat_pkg::ENTRY_W-1:0]       rd_data;
  logic [hat_pkg::KEY_W-1:0]         rd_key;
  logic [hat_pkg::SUM_W-1:0]         rd_sum;
  logic                              occ;
  logic                              match;
  logic [hat_pkg::IDX_W-1:0]         sq_step;
  logic [hat_pkg::IDX_W-1:0]         idx_step;
  logic                              wrap;
  logic                              out_free;
  logic                              done;
  logic                              fin;
  logic                              occ_set;
  logic                              in_ready;
  hat_pkg::status_t                  res_status;
  logic [hat_pkg::SUM_W-1:0]         res_sum;
  logic [hat_pkg::SLOT_W-1:0]        res_slot;

  assign in_home  = in_ch.key[hat_pkg::IDX_W-1:0];
  assign rd_key   = rd_data[hat_pkg::ENTRY_W-1:hat_pkg::SUM_W];
  assign rd_sum   = rd_data[hat_pkg::SUM_W-1:0];
  assign occ      = occupied_r[cur_idx_r];
  assign match    = occ && (rd_key == key_r);
  assign sq_step  = sq_r + delta_r;
  assign idx_step = home_r + sq_step;
  assign wrap     = (idx_step == home_r);
  assign out_free = !out_valid_r || out_ch.ready;

  hat_ram #(
    .WIDTH (hat_pkg::ENTRY_W),
    .DEPTH (hat_pkg::TABLE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_idx_r),
    .wdata ({key_r, wr_sum}),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    home_nxt    = home_r;
    cur_idx_nxt = cur_idx_r;
    sq_nxt      = sq_r;
    delta_nxt   = delta_r;
    ram_raddr   = cur_idx_r;
    ram_we      = 1'b0;
    wr_sum      = val_r;
    done        = 1'b0;
    fin         = 1'b0;
    occ_set     = 1'b0;
    in_ready    = 1'b0;
    res_status  = hat_pkg::ST_FULL;
    res_sum     = '0;
    res_slot    = '0;
    case (phase_r)
      hat_pkg::PH_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_home;
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          key_nxt     = in_ch.key;
          val_nxt     = in_ch.value;
          home_nxt    = in_home;
          cur_idx_nxt = in_home;
          sq_nxt      = '0;
          delta_nxt   = hat_pkg::IDX_W'(1);
          phase_nxt   = hat_pkg::PH_PROBE;
        end
      end
      hat_pkg::PH_PROBE: begin
        if (kind_r == hat_pkg::KIND_INSERT) begin
          if (!occ) begin
            done       = 1'b1;
            res_status = hat_pkg::ST_NEW;
            wr_sum     = val_r;
            res_sum    = val_r;
            res_slot   = hat_pkg::SLOT_W'(cur_idx_r);
          end else if (match) begin
            done       = 1'b1;
            res_status = hat_pkg::ST_ADDED;
            wr_sum     = rd_sum + val_r;
            res_sum    = rd_sum + val_r;
            res_slot   = hat_pkg::SLOT_W'(cur_idx_r);
          end
        end else begin
          if (!occ) begin
            done       = 1'b1;
            res_status = hat_pkg::ST_MISS;
            res_sum    = hat_pkg::MISS_SUM;
          end else if (match) begin
            done       = 1'b1;
            res_status = hat_pkg::ST_HIT;
            res_sum    = rd_sum;
            res_slot   = hat_pkg::SLOT_W'(cur_idx_r);
          end
        end
        if (!done && wrap) begin
          done = 1'b1;
          if (kind_r == hat_pkg::KIND_INSERT) begin
            res_status = hat_pkg::ST_FULL;
            res_sum    = '0;
          end else begin
            res_status = hat_pkg::ST_MISS;
            res_sum    = hat_pkg::MISS_SUM;
          end
        end
        if (done) begin
          // hold the read address while the output register is busy
          if (out_free) begin
            fin       = 1'b1;
            phase_nxt = hat_pkg::PH_IDLE;
            if (kind_r == hat_pkg::KIND_INSERT &&
                (res_status == hat_pkg::ST_NEW || res_status == hat_pkg::ST_ADDED)) begin
              ram_we = 1'b1;
            end
            occ_set = (res_status == hat_pkg::ST_NEW);
          end
        end else begin
          ram_raddr   = idx_step;
          cur_idx_nxt = idx_step;
          sq_nxt      = sq_step;
          delta_nxt   = delta_r + hat_pkg::IDX_W'(2);
        end
      end
      default: begin
        phase_nxt = hat_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hat_pkg::PH_IDLE;
      occupied_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (occ_set) begin
        occupied_r[cur_idx_r] <= 1'b1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    home_r    <= home_nxt;
    cur_idx_r <= cur_idx_nxt;
    sq_r      <= sq_nxt;
    delta_r   <= delta_nxt;
    if (fin) begin
      out_status_r <= res_status;
      out_sum_r    <= res_sum;
      out_slot_r   <= res_slot;
    end
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.sum    = out_sum_r;
  assign out_ch.slot   = out_slot_r;

  a_write_in_probe : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (phase_r == hat_pkg::PH_PROBE && fin))
    else $error("entry write outside a finishing probe");

  a_finish_gives_word : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hat_pkg::PH_PROBE && phase_nxt == hat_pkg::PH_IDLE) |=> out_valid_r)
    else $error("finished item left no result word");

  a_new_sets_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (fin && res_status == hat_pkg::ST_NEW) |=> occupied_r[$past(cur_idx_r)])
    else $error("new entry not marked occupied");

  a_flags_only_grow : assert property (@(posedge clk) disable iff (!rst_n)
    ##1 ((occupied_r & $past(occupied_r)) == $past(occupied_r)))
    else $error("occupancy flag cleared outside reset");

endmodule
